/* hw/rtl/stepper_trapezoid_ramp_defines.svh */
// Assertion macros for the move generator
`ifndef STEPPER_TRAPEZOID_RAMP_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_DEFINES_SVH

`define STR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define STR_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/str_pkg.sv */
package str_pkg;

   localparam int MUL_A_W   = 48;
   localparam int MUL_B_W   = 32;
   localparam int PROD_W    = 64;
   localparam int DIV_N_W   = 64;
   localparam int DIV_D_W   = 48;
   localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] OP_MOVE = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_STOP = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_TIME    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RPM       = 2'd3;

   localparam logic [15:0] RST_STEPS_PER_REV = 16'd200;
   localparam logic [15:0] RST_LEAD          = 16'd2048;
   localparam logic [15:0] RST_ACCEL_TIME    = 16'd1000;
   localparam logic [13:0] RST_MIN_RPM       = 14'd160;

   localparam logic [28:0] PERIOD_NUM = 29'd480000000;
   localparam logic [21:0] RAMP_DIV   = 22'd3840000;
   localparam logic [20:0] HALF_RAMP  = 21'd1920000;
   localparam logic [14:0] RUN_DIV    = 15'd19200;
   localparam logic [15:0] NO_PERIOD  = 16'hFFFF;
   localparam logic [13:0] SPEED_MAX  = 14'h3FFF;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } div_req_type;

endpackage

/* hw/rtl/str_chan_if.sv */
interface str_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [17:0] distance_q8;
   logic signed [14:0] speed_q4;

   modport source (output valid, operation, distance_q8, speed_q4, input ready);
   modport sink (input valid, operation, distance_q8, speed_q4, output ready);
endinterface

interface str_rsp_if;
   logic               valid;
   logic               ready;
   logic               step_level;
   logic               direction;
   logic               driver_awake;
   logic               moving;
   logic [15:0]        timer_period;
   logic signed [17:0] move_distance_q8;

   modport source (output valid, step_level, direction, driver_awake, moving,
                   timer_period, move_distance_q8, input ready);
   modport sink (input valid, step_level, direction, driver_awake, moving,
                 timer_period, move_distance_q8, output ready);
endinterface

/* hw/rtl/str_mul.sv */
module str_mul
   import str_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mul_req_type       req,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   logic               busy_ff, busy_in;
   logic [PROD_W-1:0]  a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         a_in    = PROD_W'(req.a);
         b_in    = req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[PROD_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[MUL_B_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = busy_ff && (b_ff == '0);
   assign product = acc_ff;

endmodule

/* hw/rtl/str_div.sv */
module str_div
   import str_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient,
   output logic [DIV_D_W-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   num_ff, num_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_D_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, num_ff[DIV_N_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_N_W);
         num_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (trial >= {1'b0, den_ff}) begin
               rem_in = DIV_D_W'(trial - {1'b0, den_ff});
               num_in = {num_ff[DIV_N_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIV_D_W-1:0];
               num_in = {num_ff[DIV_N_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = busy_ff && (cnt_ff == '0);
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/stepper_trapezoid_ramp.sv */
// Stop, zero speed and idle expiry go straight to the done state; an expiry that steps,
// a run and a move first compute through the bit-serial multiplier and divider.
// Each multiply shifts and adds over the bits of its narrow operand (up to 21),
// each divide yields 64 quotient bits; one transaction in flight, next accept in the cycle
// after the result loads; a new result is held in the done state while a loaded one waits.
// Reset: synchronous, restores register defaults and clears the move state.
`include "stepper_trapezoid_ramp_defines.svh"

module stepper_trapezoid_ramp
   import str_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   str_req_if.sink               req_chan,
   str_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = COUNT_WIDTH;
   localparam logic [CW-1:0] CMAX = '1;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_MWAIT = 5'd1;
   localparam logic [4:0] ST_DWAIT = 5'd2;
   localparam logic [4:0] ST_MS1   = 5'd3;
   localparam logic [4:0] ST_MS2   = 5'd4;
   localparam logic [4:0] ST_MS3   = 5'd5;
   localparam logic [4:0] ST_MN1   = 5'd6;
   localparam logic [4:0] ST_MN2   = 5'd7;
   localparam logic [4:0] ST_MN3   = 5'd8;
   localparam logic [4:0] ST_MCMP  = 5'd9;
   localparam logic [4:0] ST_MQ    = 5'd10;
   localparam logic [4:0] ST_R1    = 5'd11;
   localparam logic [4:0] ST_R2    = 5'd12;
   localparam logic [4:0] ST_R3    = 5'd13;
   localparam logic [4:0] ST_SP0   = 5'd14;
   localparam logic [4:0] ST_SP1   = 5'd15;
   localparam logic [4:0] ST_SP2   = 5'd16;
   localparam logic [4:0] ST_PER0  = 5'd17;
   localparam logic [4:0] ST_PER1  = 5'd18;
   localparam logic [4:0] ST_PER2  = 5'd19;
   localparam logic [4:0] ST_MV0   = 5'd20;
   localparam logic [4:0] ST_MV1   = 5'd21;
   localparam logic [4:0] ST_MV2   = 5'd22;
   localparam logic [4:0] ST_DONE  = 5'd23;

   logic [4:0]  state_ff, state_in;
   logic [4:0]  ret_ff, ret_in;

   logic [15:0] spr_ff, spr_in;
   logic [15:0] lead_ff, lead_in;
   logic [15:0] accel_ff, accel_in;
   logic [13:0] minrpm_ff, minrpm_in;

   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] rue_ff, rue_in;
   logic [CW-1:0] rds_ff, rds_in;
   logic [13:0]   present_ff, present_in;
   logic [13:0]   goal_ff, goal_in;
   logic          busy_ff, busy_in;
   logic          dir_ff, dir_in;
   logic          pin_ff, pin_in;
   logic          awake_ff, awake_in;

   logic [1:0]    op_ff, op_in;
   logic [13:0]   spd_ff, spd_in;
   logic [17:0]   mag_ff, mag_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [47:0]   n_ff, n_in;
   logic [CW-1:0] sden_ff, sden_in;
   logic          dneg_ff, dneg_in;
   logic [15:0]   period_ff, period_in;
   logic [17:0]   moved_ff, moved_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W-1:0] rmd_ff, rmd_in;

   mul_req_type mreq_ff, mreq_in;
   div_req_type dreq_ff, dreq_in;
   logic               mul_done, div_done;
   logic [PROD_W-1:0]  mul_prod;
   logic [DIV_N_W-1:0] div_quo;
   logic [DIV_D_W-1:0] div_rmd;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_pin_ff, rsp_pin_in;
   logic        rsp_dir_ff, rsp_dir_in;
   logic        rsp_awake_ff, rsp_awake_in;
   logic        rsp_busy_ff, rsp_busy_in;
   logic [15:0] rsp_period_ff, rsp_period_in;
   logic [17:0] rsp_moved_ff, rsp_moved_in;

   logic [14:0]        sabs;
   logic [13:0]        req_spd;
   logic               req_spos;
   logic [17:0]        req_mag;
   logic               req_dpos;
   logic [13:0]        dabs;
   logic [CW-1:0]      span, prog;
   logic signed [17:0] vs;
   logic [DIV_N_W-1:0] qr, qm1;
   logic [CW-1:0]      qs;

   str_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mreq_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   str_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (dreq_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rmd)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      sabs     = req_chan.speed_q4[14] ? 15'(-req_chan.speed_q4) : 15'(req_chan.speed_q4);
      req_spd  = (sabs > 15'(SPEED_MAX)) ? SPEED_MAX : sabs[13:0];
      req_spos = !req_chan.speed_q4[14] && (req_chan.speed_q4 != '0);
      req_mag  = req_chan.distance_q8[17] ? 18'(-req_chan.distance_q8)
                                          : 18'(req_chan.distance_q8);
      req_dpos = !req_chan.distance_q8[17] && (req_chan.distance_q8 != '0);
      dabs     = (goal_ff < minrpm_ff) ? (minrpm_ff - goal_ff) : (goal_ff - minrpm_ff);
      span     = (total_ff > rue_ff) ? (total_ff - rue_ff) : '0;
      prog     = (total_ff > rem_ff) ? (total_ff - rem_ff) : '0;
      if (prog > span) begin
         prog = span;
      end
      vs  = dneg_ff ? (18'(minrpm_ff) - 18'(quo_ff[14:0]))
                    : (18'(minrpm_ff) + 18'(quo_ff[14:0]));
      qr  = quo_ff + DIV_N_W'(rmd_ff != '0);
      qs  = (qr > DIV_N_W'(CMAX)) ? CMAX : qr[CW-1:0];
      qm1 = quo_ff - 1'b1;
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      spr_in     = spr_ff;
      lead_in    = lead_ff;
      accel_in   = accel_ff;
      minrpm_in  = minrpm_ff;
      rem_in     = rem_ff;
      total_in   = total_ff;
      rue_in     = rue_ff;
      rds_in     = rds_ff;
      present_in = present_ff;
      goal_in    = goal_ff;
      busy_in    = busy_ff;
      dir_in     = dir_ff;
      pin_in     = pin_ff;
      awake_in   = awake_ff;
      op_in      = op_ff;
      spd_in     = spd_ff;
      mag_in     = mag_ff;
      steps_in   = steps_ff;
      n_in       = n_ff;
      sden_in    = sden_ff;
      dneg_in    = dneg_ff;
      period_in  = period_ff;
      moved_in   = moved_ff;
      prod_in    = prod_ff;
      quo_in     = quo_ff;
      rmd_in     = rmd_ff;
      mreq_in       = mreq_ff;
      mreq_in.start = 1'b0;
      dreq_in       = dreq_ff;
      dreq_in.start = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_pin_in    = rsp_pin_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_awake_in  = rsp_awake_ff;
      rsp_busy_in   = rsp_busy_ff;
      rsp_period_in = rsp_period_ff;
      rsp_moved_in  = rsp_moved_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_STEPS_PER_REV: spr_in    = csr_wdata;
            CSR_LEAD:          lead_in   = csr_wdata;
            CSR_ACCEL_TIME:    accel_in  = csr_wdata;
            CSR_MIN_RPM:       minrpm_in = csr_wdata[13:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.operation;
               spd_in    = req_spd;
               mag_in    = req_mag;
               period_in = NO_PERIOD;
               moved_in  = '0;
               state_in  = ST_DONE;
               case (req_chan.operation)
                  OP_MOVE: begin
                     if (req_spd != '0) begin
                        dir_in   = req_dpos;
                        state_in = ST_MS1;
                     end
                  end
                  OP_RUN: begin
                     if (req_spd != '0) begin
                        dir_in   = !req_spos;
                        state_in = ST_R1;
                     end
                  end
                  OP_TICK: begin
                     if (rem_ff == '0 || !busy_ff) begin
                        busy_in  = 1'b0;
                        total_in = '0;
                        awake_in = 1'b0;
                     end else begin
                        pin_in   = !pin_ff;
                        rem_in   = rem_ff - 1'b1;
                        state_in = ST_SP0;
                     end
                  end
                  default: begin
                     awake_in = 1'b0;
                     busy_in  = 1'b0;
                  end
               endcase
            end
         end
         ST_MWAIT: begin
            if (mul_done) begin
               prod_in  = mul_prod;
               state_in = ret_ff;
            end
         end
         ST_DWAIT: begin
            if (div_done) begin
               quo_in   = div_quo;
               rmd_in   = div_rmd;
               state_in = ret_ff;
            end
         end
         ST_MS1: begin
            mreq_in  = '{start: 1'b1, a: MUL_A_W'(mag_ff), b: MUL_B_W'(spr_ff)};
            ret_in   = ST_MS2;
            state_in = ST_MWAIT;
         end
         ST_MS2: begin
            if (lead_ff == '0) begin
               steps_in = (mag_ff == '0 || spr_ff == '0) ? '0 : CMAX;
               state_in = ST_MN1;
            end else begin
               dreq_in  = '{start: 1'b1, num: {prod_ff[PROD_W-2:0], 1'b0},
                            den: DIV_D_W'(lead_ff)};
               ret_in   = ST_MS3;
               state_in = ST_DWAIT;
            end
         end
         ST_MS3: begin
            steps_in = (quo_ff > DIV_N_W'(CMAX)) ? CMAX : quo_ff[CW-1:0];
            state_in = ST_MN1;
         end
         ST_MN1: begin
            mreq_in  = '{start: 1'b1, a: MUL_A_W'(spd_ff), b: MUL_B_W'(spr_ff)};
            ret_in   = ST_MN2;
            state_in = ST_MWAIT;
         end
         ST_MN2: begin
            mreq_in  = '{start: 1'b1, a: prod_ff[MUL_A_W-1:0], b: MUL_B_W'(accel_ff)};
            ret_in   = ST_MN3;
            state_in = ST_MWAIT;
         end
         ST_MN3: begin
            n_in     = prod_ff[47:0];
            mreq_in  = '{start: 1'b1, a: MUL_A_W'(steps_ff), b: MUL_B_W'(HALF_RAMP)};
            ret_in   = ST_MCMP;
            state_in = ST_MWAIT;
         end
         ST_MCMP: begin
            if (PROD_W'(n_ff) > prod_ff) begin
               rds_in   = steps_ff >> 1;
               rue_in   = steps_ff >> 1;
               rem_in   = steps_ff;
               total_in = steps_ff;
               goal_in  = spd_ff;
               awake_in = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_SP0;
            end else begin
               dreq_in  = '{start: 1'b1, num: DIV_N_W'(n_ff), den: DIV_D_W'(RAMP_DIV)};
               ret_in   = ST_MQ;
               state_in = ST_DWAIT;
            end
         end
         ST_MQ: begin
            rds_in   = quo_ff[CW-1:0];
            rue_in   = steps_ff - quo_ff[CW-1:0] - CW'(rmd_ff != '0);
            rem_in   = steps_ff;
            total_in = steps_ff;
            goal_in  = spd_ff;
            awake_in = 1'b1;
            busy_in  = 1'b1;
            state_in = ST_SP0;
         end
         ST_R1: begin
            mreq_in  = '{start: 1'b1, a: MUL_A_W'(spd_ff), b: MUL_B_W'(spr_ff)};
            ret_in   = ST_R2;
            state_in = ST_MWAIT;
         end
         ST_R2: begin
            dreq_in  = '{start: 1'b1, num: prod_ff, den: DIV_D_W'(RUN_DIV)};
            ret_in   = ST_R3;
            state_in = ST_DWAIT;
         end
         ST_R3: begin
            rem_in   = CMAX;
            total_in = CMAX;
            rue_in   = CMAX - qs;
            rds_in   = '0;
            goal_in  = spd_ff;
            awake_in = 1'b1;
            busy_in  = 1'b1;
            state_in = ST_SP0;
         end
         ST_SP0: begin
            dneg_in = (goal_ff < minrpm_ff);
            if (rem_ff > rue_ff) begin
               if (span == '0) begin
                  state_in = ST_PER0;
               end else begin
                  sden_in  = span;
                  mreq_in  = '{start: 1'b1, a: MUL_A_W'(prog), b: MUL_B_W'(dabs)};
                  ret_in   = ST_SP1;
                  state_in = ST_MWAIT;
               end
            end else if (rem_ff < rds_ff) begin
               sden_in  = rds_ff;
               mreq_in  = '{start: 1'b1, a: MUL_A_W'(rem_ff), b: MUL_B_W'(dabs)};
               ret_in   = ST_SP1;
               state_in = ST_MWAIT;
            end else begin
               present_in = goal_ff;
               state_in   = ST_PER0;
            end
         end
         ST_SP1: begin
            dreq_in  = '{start: 1'b1, num: prod_ff, den: DIV_D_W'(sden_ff)};
            ret_in   = ST_SP2;
            state_in = ST_DWAIT;
         end
         ST_SP2: begin
            if (vs < 0) begin
               present_in = '0;
            end else if (vs > 18'sd16383) begin
               present_in = SPEED_MAX;
            end else begin
               present_in = vs[13:0];
            end
            state_in = ST_PER0;
         end
         ST_PER0: begin
            mreq_in  = '{start: 1'b1, a: MUL_A_W'(present_ff), b: MUL_B_W'(spr_ff)};
            ret_in   = ST_PER1;
            state_in = ST_MWAIT;
         end
         ST_PER1: begin
            if (prod_ff == '0) begin
               period_in = NO_PERIOD;
               state_in  = (op_ff == OP_MOVE) ? ST_MV0 : ST_DONE;
            end else begin
               dreq_in  = '{start: 1'b1, num: DIV_N_W'(PERIOD_NUM),
                            den: prod_ff[DIV_D_W-1:0]};
               ret_in   = ST_PER2;
               state_in = ST_DWAIT;
            end
         end
         ST_PER2: begin
            if (quo_ff == '0) begin
               period_in = '0;
            end else if (qm1 > DIV_N_W'(NO_PERIOD)) begin
               period_in = NO_PERIOD;
            end else begin
               period_in = qm1[15:0];
            end
            state_in = (op_ff == OP_MOVE) ? ST_MV0 : ST_DONE;
         end
         ST_MV0: begin
            if (spr_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               mreq_in  = '{start: 1'b1, a: MUL_A_W'(steps_ff), b: MUL_B_W'(lead_ff)};
               ret_in   = ST_MV1;
               state_in = ST_MWAIT;
            end
         end
         ST_MV1: begin
            dreq_in  = '{start: 1'b1, num: prod_ff, den: DIV_D_W'({spr_ff, 1'b0})};
            ret_in   = ST_MV2;
            state_in = ST_DWAIT;
         end
         ST_MV2: begin
            moved_in = dir_ff ? quo_ff[17:0] : 18'(-quo_ff[17:0]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pin_in    = pin_ff;
               rsp_dir_in    = dir_ff;
               rsp_awake_in  = awake_ff;
               rsp_busy_in   = busy_ff;
               rsp_period_in = period_ff;
               rsp_moved_in  = moved_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         spr_ff        <= RST_STEPS_PER_REV;
         lead_ff       <= RST_LEAD;
         accel_ff      <= RST_ACCEL_TIME;
         minrpm_ff     <= RST_MIN_RPM;
         rem_ff        <= '0;
         total_ff      <= '0;
         rue_ff        <= '0;
         rds_ff        <= '0;
         present_ff    <= RST_MIN_RPM;
         goal_ff       <= '0;
         busy_ff       <= 1'b0;
         dir_ff        <= 1'b0;
         pin_ff        <= 1'b0;
         awake_ff      <= 1'b0;
         mreq_ff.start <= 1'b0;
         dreq_ff.start <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         spr_ff        <= spr_in;
         lead_ff       <= lead_in;
         accel_ff      <= accel_in;
         minrpm_ff     <= minrpm_in;
         rem_ff        <= rem_in;
         total_ff      <= total_in;
         rue_ff        <= rue_in;
         rds_ff        <= rds_in;
         present_ff    <= present_in;
         goal_ff       <= goal_in;
         busy_ff       <= busy_in;
         dir_ff        <= dir_in;
         pin_ff        <= pin_in;
         awake_ff      <= awake_in;
         mreq_ff       <= mreq_in;
         dreq_ff       <= dreq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      op_ff         <= op_in;
      spd_ff        <= spd_in;
      mag_ff        <= mag_in;
      steps_ff      <= steps_in;
      n_ff          <= n_in;
      sden_ff       <= sden_in;
      dneg_ff       <= dneg_in;
      period_ff     <= period_in;
      moved_ff      <= moved_in;
      prod_ff       <= prod_in;
      quo_ff        <= quo_in;
      rmd_ff        <= rmd_in;
      rsp_pin_ff    <= rsp_pin_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_awake_ff  <= rsp_awake_in;
      rsp_busy_ff   <= rsp_busy_in;
      rsp_period_ff <= rsp_period_in;
      rsp_moved_ff  <= rsp_moved_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.step_level       = rsp_pin_ff;
   assign rsp_chan.direction        = rsp_dir_ff;
   assign rsp_chan.driver_awake     = rsp_awake_ff;
   assign rsp_chan.moving           = rsp_busy_ff;
   assign rsp_chan.timer_period     = rsp_period_ff;
   assign rsp_chan.move_distance_q8 = rsp_moved_ff;

   `STR_ASSERT(a_accept_leaves_idle, clock, reset,
      req_chan.valid && req_chan.ready |=> state_ff != ST_IDLE, "accept did not start work")
   `STR_ASSERT(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE, "response loaded outside done")
   `STR_NEVER(a_units_exclusive, clock, reset,
      mul_done && div_done, "multiplier and divider finished together")

endmodule

/* dv/str_ramp_checker.sv */
module str_ramp_checker
   import str_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   str_req_if                    req,
   str_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending,
   output int                    results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               step_level;
      logic               direction;
      logic               driver_awake;
      logic               moving;
      logic [15:0]        timer_period;
      logic signed [17:0] move_distance_q8;
   } pin_state_type;

   pin_state_type expected_pins[$];

   logic [15:0] spr, lead, accel_ms;
   logic [13:0] min_rpm;
   logic [31:0] steps_left, steps_total, up_end, down_start;
   logic [13:0] cur_rpm, target_rpm;
   logic        running, cw, pin, wake;

   task automatic clear_motion();
      spr = RST_STEPS_PER_REV;
      lead = RST_LEAD;
      accel_ms = RST_ACCEL_TIME;
      min_rpm = RST_MIN_RPM;
      steps_left = '0;
      steps_total = '0;
      up_end = '0;
      down_start = '0;
      cur_rpm = RST_MIN_RPM;
      target_rpm = '0;
      running = 1'b0;
      cw = 1'b0;
      pin = 1'b0;
      wake = 1'b0;
   endtask

   task automatic ramp_rpm();
      longint lo, delta, v, span, prog;
      lo = longint'(min_rpm);
      delta = longint'(target_rpm) - lo;
      if (steps_left > up_end) begin
         span = (steps_total > up_end) ? longint'(steps_total - up_end) : 0;
         prog = (steps_total > steps_left) ? longint'(steps_total - steps_left) : 0;
         if (prog > span) prog = span;
         if (span == 0) return;
         v = lo + (delta * prog) / span;
      end else if (steps_left < down_start) begin
         v = lo + (delta * longint'(steps_left)) / longint'(down_start);
      end else begin
         v = longint'(target_rpm);
      end
      if (v < 0) v = 0;
      if (v > 16383) v = 16383;
      cur_rpm = v[13:0];
   endtask

   function automatic logic [15:0] half_step_period();
      longint unsigned den, q;
      den = longint'(cur_rpm) * longint'(spr);
      if (den == 0) return NO_PERIOD;
      q = 64'd480000000 / den;
      if (q == 0) return 16'd0;
      q = q - 1;
      return (q > 65535) ? NO_PERIOD : q[15:0];
   endfunction

   task automatic predict_pins(input logic [1:0] op, input logic signed [17:0] distance,
                               input logic signed [14:0] spd_in, output pin_state_type res);
      longint unsigned mag, steps, n, q, r, spd;
      longint d, s, moved;
      logic [15:0] period;
      logic positive;
      period = NO_PERIOD;
      moved = 0;
      s = longint'(spd_in);
      positive = (s > 0);
      if (s < 0) s = -s;
      if (s > 16383) s = 16383;
      spd = s;
      if (op == OP_MOVE && spd != 0) begin
         d = longint'(distance);
         cw = (d > 0);
         mag = (d < 0) ? -d : d;
         if (lead == 0)
            steps = (mag == 0 || spr == 0) ? 0 : COUNT_MAX;
         else
            steps = (mag * spr * 2) / lead;
         if (steps > COUNT_MAX) steps = COUNT_MAX;
         n = spd * spr * accel_ms;
         if (n > steps * 64'd1920000) begin
            q = steps >> 1;
            up_end = q[31:0];
         end else begin
            q = n / 64'd3840000;
            r = n % 64'd3840000;
            up_end = 32'(steps - q - ((r != 0) ? 1 : 0));
         end
         down_start = q[31:0];
         steps_left = steps[31:0];
         steps_total = steps[31:0];
         target_rpm = spd[13:0];
         wake = 1'b1;
         running = 1'b1;
         ramp_rpm();
         period = half_step_period();
         if (spr != 0) moved = longint'((steps * lead) / (longint'(spr) * 2));
         if (!cw) moved = -moved;
      end else if (op == OP_RUN && spd != 0) begin
         n = spd * spr;
         q = n / 19200 + (((n % 19200) != 0) ? 1 : 0);
         cw = !positive;
         if (q > COUNT_MAX) q = COUNT_MAX;
         steps_left = COUNT_MAX;
         steps_total = COUNT_MAX;
         up_end = COUNT_MAX - q[31:0];
         down_start = '0;
         target_rpm = spd[13:0];
         wake = 1'b1;
         running = 1'b1;
         ramp_rpm();
         period = half_step_period();
      end else if (op == OP_TICK) begin
         if (steps_left == 0 || !running) begin
            running = 1'b0;
            steps_total = '0;
            wake = 1'b0;
         end else begin
            pin = !pin;
            steps_left = steps_left - 1;
            ramp_rpm();
            period = half_step_period();
         end
      end else if (op == OP_STOP) begin
         wake = 1'b0;
         running = 1'b0;
      end
      res.step_level = pin;
      res.direction = cw;
      res.driver_awake = wake;
      res.moving = running;
      res.timer_period = period;
      res.move_distance_q8 = moved[17:0];
   endtask

   always @(posedge clock) begin
      pin_state_type want, got;
      if (reset) begin
         clear_motion();
         expected_pins.delete();
         mismatches = 0;
         results_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEPS_PER_REV: spr = csr_wdata;
               CSR_LEAD:          lead = csr_wdata;
               CSR_ACCEL_TIME:    accel_ms = csr_wdata;
               CSR_MIN_RPM:       min_rpm = csr_wdata[13:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.step_level, rsp.direction, rsp.driver_awake, rsp.moving,
                    rsp.timer_period, rsp.move_distance_q8};
            results_seen++;
            if (expected_pins.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction %p", got);
            end else begin
               want = expected_pins.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: expected %p, actual %p", $realtime, want, got);
               end
            end
         end
         if (req.valid && req.ready) begin
            predict_pins(req.operation, req.distance_q8, req.speed_q4, want);
            expected_pins.push_back(want);
         end
      end
      pending = expected_pins.size();
   end

   final begin
      if (expected_pins.size() != 0) $display("%0d transactions never arrived", pending);
   end
endmodule

/* dv/tb_stepper_trapezoid_ramp.sv */
module tb_stepper_trapezoid_ramp;
   import str_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches, pending, results_seen;
   int                    sent, burst_left, leftover;
   int                    op_count[4];

   str_req_if req_chan();
   str_rsp_if rsp_chan();

   stepper_trapezoid_ramp u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   str_ramp_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = OP_STOP;
      req_chan.distance_q8 = '0;
      req_chan.speed_q4 = '0;
      rsp_chan.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_STEPS_PER_REV;
      csr_wdata = '0;
      reset = 1'b1;
   end

   // watchdog
   initial begin
      repeat (3000000) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // receiver: hold off once for a long stretch, then stall on shifting patterns
   initial begin
      int mode, k;
      repeat (3000) begin
         @(negedge clock);
         rsp_chan.ready = ($urandom_range(0, 3) != 0);
      end
      @(negedge clock);
      rsp_chan.ready = 1'b0;
      repeat (4000) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         for (k = 0; k < int'($urandom_range(100, 400)); k++) begin
            case (mode)
               0: rsp_chan.ready = 1'b1;
               1: rsp_chan.ready = 1'($urandom_range(0, 1));
               2: rsp_chan.ready = (k % 7) < 2;
               default: rsp_chan.ready = ($urandom_range(0, 9) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic send(input logic [1:0] op, input logic signed [17:0] distance,
                       input logic signed [14:0] spd);
      int gap;
      req_chan.valid = 1'b1;
      req_chan.operation = op;
      req_chan.distance_q8 = distance;
      req_chan.speed_q4 = spd;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      sent++;
      op_count[op]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic settle();
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic configure(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input logic [15:0] d);
      settle();
      write_reg(CSR_STEPS_PER_REV, a);
      write_reg(CSR_LEAD, b);
      write_reg(CSR_ACCEL_TIME, c);
      write_reg(CSR_MIN_RPM, d);
   endtask

   function automatic logic signed [14:0] any_speed();
      if ($urandom_range(0, 9) == 0) return 15'($urandom_range(0, 32767));
      return $urandom_range(0, 1) ? 15'sd0 + 15'($urandom_range(1, 16383))
                                  : -15'($urandom_range(1, 16384));
   endfunction

   task automatic random_phase(input int count);
      int kind, n;
      logic signed [17:0] distance;
      while (count > 0) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            distance = $urandom_range(0, 3) == 0 ? 18'($urandom)
                                                  : 18'($signed($urandom_range(0, 200)) - 100);
            send(OP_MOVE, distance, any_speed());
            n = $urandom_range(1, 30);
            repeat (n) send(OP_TICK, 18'($urandom), 15'($urandom));
            count -= n + 1;
         end else if (kind < 8) begin
            send(OP_RUN, 18'($urandom), any_speed());
            n = $urandom_range(1, 25);
            repeat (n) send(OP_TICK, 18'($urandom), 15'($urandom));
            send(OP_STOP, 18'($urandom), 15'($urandom));
            count -= n + 2;
         end else begin
            send(2'($urandom), 18'($urandom), 15'($urandom));
            count--;
         end
      end
   endtask

   initial begin
      sent = 0;
      burst_left = 0;
      op_count = '{default: 0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_MOVE, 18'sd512, 15'sd0);
      send(OP_RUN, 18'sd0, 15'sd0);
      send(OP_MOVE, 18'sd0, 15'sd800);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_MOVE, 18'sd20, -15'sd16384);
      repeat (6) send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_MOVE, 18'sh1FFFF, 15'sd16383);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_STOP, 18'sd0, 15'sd0);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_MOVE, -18'sd131072, 15'sd1);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_RUN, 18'sd0, 15'sd16383);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_RUN, 18'sd0, -15'sd5);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_STOP, 18'sd0, 15'sd0);

      configure(16'd65535, 16'd1, 16'd65535, 16'd16383);
      send(OP_MOVE, 18'sd1, 15'sd16383);
      send(OP_TICK, 18'sd0, 15'sd0);
      send(OP_STOP, 18'sd0, 15'sd0);
      random_phase(90);

      configure(16'd1, 16'd65535, 16'd0, 16'd1);
      random_phase(90);

      configure(16'd48, 16'd300, 16'd40, 16'd64);
      random_phase(100);

      configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom), 16'($urandom_range(1, 16383)));
      random_phase(90);

      configure(RST_STEPS_PER_REV, RST_LEAD, RST_ACCEL_TIME, 16'(RST_MIN_RPM));
      random_phase(110);

      req_chan.valid = 1'b0;
      leftover = 0;
      while (pending != 0 && leftover < 2000000) begin
         @(posedge clock);
         leftover++;
      end
      repeat (500) @(posedge clock);
      $display("covered %0d transactions (move %0d, run %0d, expiry %0d, stop %0d)",
               sent, op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("checked %0d results over five register settings", results_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/str_pkg.sv
hw/rtl/str_chan_if.sv
hw/rtl/str_mul.sv
hw/rtl/str_div.sv
hw/rtl/stepper_trapezoid_ramp.sv
dv/str_ramp_checker.sv
dv/tb_stepper_trapezoid_ramp.sv
